// ===== hw/rtl/eatrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eatrm_pkg
// types, constants and helpers for the euler angle to rotation matrix block
// ----------------------------------------------------------------------------
package eatrm_pkg;

  localparam int ANGLE_BITS_DEF          = 16;
  localparam int ENTRY_FRACTION_BITS_DEF = 14;
  localparam int CORDIC_STAGES_DEF       = 16;

  localparam int FIELD_W = 16;
  localparam int XY_W    = 34;
  localparam int Z_W     = 33;
  localparam int Q_W     = 32;

  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [Q_W-1:0]  Q30_ONE  = 32'sd1073741824;

  typedef struct packed {
    logic signed [FIELD_W-1:0] angle_a;
    logic signed [FIELD_W-1:0] angle_b;
    logic signed [FIELD_W-1:0] angle_c;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m00;
    logic signed [FIELD_W-1:0] m10;
    logic signed [FIELD_W-1:0] m20;
    logic signed [FIELD_W-1:0] m01;
    logic signed [FIELD_W-1:0] m11;
    logic signed [FIELD_W-1:0] m21;
    logic signed [FIELD_W-1:0] m02;
    logic signed [FIELD_W-1:0] m12;
    logic signed [FIELD_W-1:0] m22;
  } out_item_t;

  typedef logic signed [Q_W-1:0] q30_t;

  typedef struct packed {
    q30_t ca;
    q30_t sa;
    q30_t cb;
    q30_t sb;
    q30_t cc;
    q30_t sc;
  } trig_t;

  function automatic logic signed [Z_W-1:0] atan_turn(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0: r = 33'sd536870912;   1: r = 33'sd316933406;
      2: r = 33'sd167458907;   3: r = 33'sd85004756;
      4: r = 33'sd42667331;    5: r = 33'sd21354465;
      6: r = 33'sd10680862;    7: r = 33'sd5340245;
      8: r = 33'sd2670163;     9: r = 33'sd1335087;
      10: r = 33'sd667544;     11: r = 33'sd333772;
      12: r = 33'sd166886;     13: r = 33'sd83443;
      14: r = 33'sd41722;      15: r = 33'sd20861;
      16: r = 33'sd10430;      17: r = 33'sd5215;
      18: r = 33'sd2608;       19: r = 33'sd1304;
      20: r = 33'sd652;        21: r = 33'sd326;
      22: r = 33'sd163;        23: r = 33'sd81;
      24: r = 33'sd41;         25: r = 33'sd20;
      26: r = 33'sd10;         27: r = 33'sd5;
      28: r = 33'sd3;          29: r = 33'sd1;
      30: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q30 product, rounded
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return q30_t'(p >>> 30);
  endfunction

endpackage

// ===== hw/rtl/eatrm_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eatrm_cordic
// unrolled rotation-mode cordic, one stage per register, gives cos and sin
// ----------------------------------------------------------------------------
module eatrm_cordic #(
  parameter int ANGLE_BITS    = eatrm_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = eatrm_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [eatrm_pkg::FIELD_W-1:0] angle,
  output eatrm_pkg::q30_t                      cos_q,
  output eatrm_pkg::q30_t                      sin_q
);

  localparam int XW = eatrm_pkg::XY_W;
  localparam int ZW = eatrm_pkg::Z_W;

  logic signed [XW-1:0] x [CORDIC_STAGES+1];
  logic signed [XW-1:0] y [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z [CORDIC_STAGES+1];
  logic                 flip [CORDIC_STAGES+1];

  logic [31:0] t;
  logic [31:0] tf;
  logic        fl;

  // low ANGLE_BITS of the field scaled to a 32-bit turn
  always_comb begin
    t  = {{(32-eatrm_pkg::FIELD_W){1'b0}}, angle} << (32 - ANGLE_BITS);
    fl = t[31] ^ t[30];
    tf = fl ? t + 32'h8000_0000 : t;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= eatrm_pkg::GAIN_Q30;
      y[0]    <= '0;
      z[0]    <= {tf[31], tf};
      flip[0] <= fl;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - eatrm_pkg::atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + eatrm_pkg::atan_turn(i);
        end
      end
    end
  end

  logic signed [XW-1:0] xo;
  logic signed [XW-1:0] yo;
  localparam logic signed [XW-1:0] LIM = XW'(eatrm_pkg::Q30_ONE);

  always_comb begin
    xo = flip[CORDIC_STAGES] ? -x[CORDIC_STAGES] : x[CORDIC_STAGES];
    yo = flip[CORDIC_STAGES] ? -y[CORDIC_STAGES] : y[CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= (xo > LIM) ? eatrm_pkg::Q30_ONE : (xo < -LIM) ? -eatrm_pkg::Q30_ONE
             : eatrm_pkg::q30_t'(xo);
      sin_q <= (yo > LIM) ? eatrm_pkg::Q30_ONE : (yo < -LIM) ? -eatrm_pkg::Q30_ONE
             : eatrm_pkg::q30_t'(yo);
    end
  end

endmodule

// ===== hw/rtl/eatrm_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eatrm_matrix
// products and sums for the nine entries, three register stages
// ----------------------------------------------------------------------------
module eatrm_matrix #(
  parameter int ENTRY_FRACTION_BITS = eatrm_pkg::ENTRY_FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  eatrm_pkg::trig_t     trig,
  output eatrm_pkg::out_item_t item
);

  typedef eatrm_pkg::q30_t q_t;
  localparam int SH = 30 - ENTRY_FRACTION_BITS;
  localparam logic signed [33:0] ELIM = 34'sd1 <<< ENTRY_FRACTION_BITS;

  eatrm_pkg::trig_t r1;
  q_t t1, u1;
  q_t p00, p10, p20, p01a, p01b, p11a, p11b, p21, p02a, p02b, p12a, p12b, p22;
  logic signed [33:0] e [9];

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= trig;
      t1 <= eatrm_pkg::qmul(trig.sb, trig.sc);
      u1 <= eatrm_pkg::qmul(trig.sb, trig.cc);
      p00  <= eatrm_pkg::qmul(r1.ca, r1.cb);
      p10  <= eatrm_pkg::qmul(r1.sa, r1.cb);
      p20  <= -r1.sb;
      p01a <= eatrm_pkg::qmul(r1.ca, t1);
      p01b <= eatrm_pkg::qmul(r1.sa, r1.cc);
      p11a <= eatrm_pkg::qmul(r1.sa, t1);
      p11b <= eatrm_pkg::qmul(r1.ca, r1.cc);
      p21  <= eatrm_pkg::qmul(r1.cb, r1.sc);
      p02a <= eatrm_pkg::qmul(r1.ca, u1);
      p02b <= eatrm_pkg::qmul(r1.sa, r1.sc);
      p12a <= eatrm_pkg::qmul(r1.sa, u1);
      p12b <= eatrm_pkg::qmul(r1.ca, r1.sc);
      p22  <= eatrm_pkg::qmul(r1.cb, r1.cc);
    end
  end

  function automatic logic signed [15:0] to_entry(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = v;
    if (SH > 0) r = (v + (34'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
    if (r > ELIM) r = ELIM;
    else if (r < -ELIM) r = -ELIM;
    return r[15:0];
  endfunction

  always_comb begin
    e[0] = 34'(p00);
    e[1] = 34'(p10);
    e[2] = 34'(p20);
    e[3] = 34'(p01a) - 34'(p01b);
    e[4] = 34'(p11a) + 34'(p11b);
    e[5] = 34'(p21);
    e[6] = 34'(p02a) + 34'(p02b);
    e[7] = 34'(p12a) - 34'(p12b);
    e[8] = 34'(p22);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item.m00 <= to_entry(e[0]);
      item.m10 <= to_entry(e[1]);
      item.m20 <= to_entry(e[2]);
      item.m01 <= to_entry(e[3]);
      item.m11 <= to_entry(e[4]);
      item.m21 <= to_entry(e[5]);
      item.m02 <= to_entry(e[6]);
      item.m12 <= to_entry(e[7]);
      item.m22 <= to_entry(e[8]);
    end
  end

endmodule

// ===== hw/rtl/euler_angles_to_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix
// zyx euler angles to a 3x3 rotation matrix in q2.14
// ----------------------------------------------------------------------------
// in channel: in_valid / in_stall with in_data carrying angles a, b, c.
// out channel: out_valid / out_stall with out_data carrying nine entries.
// a transfer happens when valid is high and stall is low.
// throughput: one angle triple per cycle while out_stall does not hold a result.
// from input transfer to out_valid an item passes the input register, the
// cordic stages, the clamp, two product stages and rounding.
// the whole pipeline advances as one; when out_stall holds a result,
// every stage holds and in_stall follows, so nothing is lost or repeated.
// reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix #(
  parameter int ANGLE_BITS          = eatrm_pkg::ANGLE_BITS_DEF,
  parameter int ENTRY_FRACTION_BITS = eatrm_pkg::ENTRY_FRACTION_BITS_DEF,
  parameter int CORDIC_STAGES       = eatrm_pkg::CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  eatrm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output eatrm_pkg::out_item_t out_data
);

  localparam int DEPTH = CORDIC_STAGES + 5;

  logic             en;
  logic [DEPTH-1:0] vld;
  eatrm_pkg::trig_t trig;
  eatrm_pkg::q30_t  ca, sa, cb, sb, cc, sc;

  assign en        = !(vld[DEPTH-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[DEPTH-1];
  assign trig      = {ca, sa, cb, sb, cc, sc};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  eatrm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_ca (
    .clk(clk), .en(en), .angle(in_data.angle_a), .cos_q(ca), .sin_q(sa)
  );
  eatrm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cb (
    .clk(clk), .en(en), .angle(in_data.angle_b), .cos_q(cb), .sin_q(sb)
  );
  eatrm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cc (
    .clk(clk), .en(en), .angle(in_data.angle_c), .cos_q(cc), .sin_q(sc)
  );

  eatrm_matrix #(.ENTRY_FRACTION_BITS(ENTRY_FRACTION_BITS)) u_mat (
    .clk(clk), .en(en), .trig(trig), .item(out_data)
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall out of step with output");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    en && !vld[DEPTH-2] |=> !out_valid)
    else $error("result without an item");

endmodule

// ===== sim/euler_angles_to_rotation_matrix_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_test
// drives angle triples through the block and checks each rotation matrix
// against a bit-exact cordic and fixed-point product model kept here
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_test;

  localparam int LATENCY = eatrm_pkg::CORDIC_STAGES_DEF + 5;
  localparam int WATCHDOG_LIMIT = 2000;

  class matrix_scoreboard;
    eatrm_pkg::out_item_t pending[$];
    int mismatches;

    function longint floor_shift(longint v, int s);
      if (v < 0) return -64'sd1 - ((-64'sd1 - v) >>> s);
      return v >>> s;
    endfunction

    function longint limit(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint mul_q30(longint a, longint b);
      return floor_shift(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function longint turn_step(int i);
      longint tbl[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10680862, 5340245, 2670163, 1335087,
                          667544, 333772, 166886, 83443, 41722, 20861};
      return tbl[i];
    endfunction

    function void rotate_angle(logic [15:0] ang, output longint c,
                               output longint s);
      logic [31:0] t;
      bit flip;
      longint x, y, z, nx;
      t = {ang, 16'h0};
      flip = t[31] != t[30];
      if (flip) t = t + 32'h8000_0000;
      z = longint'(signed'(t));
      x = 652032874;
      y = 0;
      for (int i = 0; i < eatrm_pkg::CORDIC_STAGES_DEF; i++) begin
        if (z >= 0) begin
          nx = x - floor_shift(y, i);
          y = y + floor_shift(x, i);
          z = z - turn_step(i);
        end else begin
          nx = x + floor_shift(y, i);
          y = y - floor_shift(x, i);
          z = z + turn_step(i);
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = limit(x, 64'sd1 <<< 30);
      s = limit(y, 64'sd1 <<< 30);
    endfunction

    function logic [15:0] to_q14(longint v);
      longint r;
      r = floor_shift(v + (64'sd1 <<< 15), 16);
      r = limit(r, 64'sd16384);
      return r[15:0];
    endfunction

    function void note_angles(eatrm_pkg::in_item_t a);
      longint ca, sa, cb, sb, cc, sc, t, u;
      eatrm_pkg::out_item_t m;
      rotate_angle(a.angle_a, ca, sa);
      rotate_angle(a.angle_b, cb, sb);
      rotate_angle(a.angle_c, cc, sc);
      t = mul_q30(sb, sc);
      u = mul_q30(sb, cc);
      m.m00 = to_q14(mul_q30(ca, cb));
      m.m10 = to_q14(mul_q30(sa, cb));
      m.m20 = to_q14(-sb);
      m.m01 = to_q14(mul_q30(ca, t) - mul_q30(sa, cc));
      m.m11 = to_q14(mul_q30(sa, t) + mul_q30(ca, cc));
      m.m21 = to_q14(mul_q30(cb, sc));
      m.m02 = to_q14(mul_q30(ca, u) + mul_q30(sa, sc));
      m.m12 = to_q14(mul_q30(sa, u) - mul_q30(ca, sc));
      m.m22 = to_q14(mul_q30(cb, cc));
      pending.push_back(m);
    endfunction

    function void check_matrix(eatrm_pkg::out_item_t got);
      eatrm_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected matrix %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("matrix mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  eatrm_pkg::in_item_t in_data;
  eatrm_pkg::out_item_t out_data;
  matrix_scoreboard board;
  bit quiet;
  int idle_cycles;

  euler_angles_to_rotation_matrix uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_matrix(out_data);
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // watchdog on cycles without a transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_angles(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    eatrm_pkg::in_item_t item;
    item.angle_a = a;
    item.angle_b = b;
    item.angle_c = c;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    board.note_angles(item);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    logic [15:0] corners[10] = '{16'h0000, 16'h4000, 16'hC000, 16'h8000,
                                 16'h7FFF, 16'h3FFF, 16'h4001, 16'hBFFF,
                                 16'hC001, 16'hFFFF};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 9)];
    return 16'($urandom);
  endfunction

  initial begin
    logic [15:0] edges[8] = '{16'h0000, 16'h4000, 16'hC000, 16'h8000,
                              16'h7FFF, 16'h3FFF, 16'h4001, 16'hFFFF};
    board = new();
    quiet = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < 8; i++) send_angles(edges[i], edges[7 - i], edges[(i + 3) % 8]);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h2000, 16'hE000, 16'h1000);
    send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
    send_angles(16'h5555, 16'hAAAA, 16'h5555);
    drain;
    for (int n = 0; n < 500; n++) begin
      if (n == 400) quiet = 1;
      send_angles(pick_angle(), pick_angle(), pick_angle());
      if (n == 200) drain;
    end
    drain;
    repeat (LATENCY + 5) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== euler_angles_to_rotation_matrix.f =====
hw/rtl/eatrm_pkg.sv
hw/rtl/eatrm_cordic.sv
hw/rtl/eatrm_matrix.sv
hw/rtl/euler_angles_to_rotation_matrix.sv
sim/euler_angles_to_rotation_matrix_test.sv
